### hw/rtl/klo_pkg.sv
// shared types and constants for the kicker pulse lockout block
package klo_pkg;

  localparam int unsigned DtW        = 16;
  localparam int unsigned MinIntW    = 20;
  localparam int unsigned MaxPulseW  = 16;
  localparam int unsigned CfgAddrW   = 1;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned InTdataW   = 24;
  localparam int unsigned OutTdataW  = 8;
  localparam int unsigned StatusW    = 3;

  localparam logic [MinIntW-1:0]   MinIntervalRst = 20'd300000;
  localparam logic [MaxPulseW-1:0] MaxPulseRst    = 16'd15000;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MIN_INTERVAL = 1'b0,
    REG_MAX_PULSE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    ST_TICK  = 3'd0,
    ST_START = 3'd1,
    ST_ZERO  = 3'd2,
    ST_BUSY  = 3'd3,
    ST_SOON  = 3'd4
  } status_e;

  typedef struct packed {
    logic           req_type;
    logic [DtW-1:0] discharge_time;
    logic           kick_mode_raw;
  } item_t;

  typedef struct packed {
    logic    chip_line;
    logic    shoot_line;
    logic    pulse_busy;
    status_e status;
  } res_t;

  typedef struct packed {
    logic [MinIntW-1:0]   min_interval_us;
    logic [MaxPulseW-1:0] max_pulse_us;
  } cfg_t;

endpackage

### hw/rtl/kicker_pulse_lockout.sv
// top level of the solenoid kick driver with retrigger lockout
//
// Usage: each word on the slave stream is either a one microsecond tick
// (s_axis_tuser = 0) or a kick request (s_axis_tuser = 1) carrying a
// discharge time and a mode bit. Every word yields exactly one result word on
// the master stream with the chip, shoot and busy levels after that word and
// a status code in m_axis_tuser.
// Path: the input register holds each accepted word, then the decision logic
// writes the result register, and a stall on the result side can hold the
// word in between. Throughput: one word per cycle while m_axis_tready stays
// high, as the counters are compared, decremented and loaded per word.
// Config: registers are written through cfg_valid_i / cfg_addr_i / cfg_data_i,
// always ready; index 0 is the min interval in ticks, index 1 the max pulse.
// Reset: pulse and interval counters clear, so the first kick also waits the
// min interval; registers return to 300000 and 15000.
// Stall: when m_axis_tready is low the result holds; once the input and result
// registers are full s_axis_tready follows m_axis_tready in the same cycle,
// while an empty input register still takes one more word before s_axis_tready drops.
module kicker_pulse_lockout import klo_pkg::*; #(
  parameter int unsigned PULSE_BITS    = 16,
  parameter int unsigned INTERVAL_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // discharge_time, kick_mode_raw
  input  logic                 s_axis_tuser,   // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // chip_line, shoot_line, pulse_busy
  output logic [StatusW-1:0]   m_axis_tuser,   // status
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t  cfg;
  item_t in_item, item;
  logic  item_valid, item_take;
  res_t  res;

  assign in_item.req_type       = s_axis_tuser;
  assign in_item.discharge_time = s_axis_tdata[DtW-1:0];
  assign in_item.kick_mode_raw  = s_axis_tdata[DtW];

  klo_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  klo_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  klo_core #(
    .PULSE_BITS    (PULSE_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {{(OutTdataW-3){1'b0}}, res.pulse_busy, res.shoot_line, res.chip_line};
  assign m_axis_tuser = res.status;

endmodule

### hw/rtl/klo_cfg_regs.sv
// configuration register file: min interval and max pulse length
module klo_cfg_regs import klo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_MIN_INTERVAL: cfg_d.min_interval_us = cfg_data_i[MinIntW-1:0];
        REG_MAX_PULSE:    cfg_d.max_pulse_us    = cfg_data_i[MaxPulseW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval_us <= MinIntervalRst;
      cfg_q.max_pulse_us    <= MaxPulseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/klo_in_stage.sv
// input register stage between the slave stream and the core
module klo_in_stage import klo_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  input  logic  item_take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // refill in the same cycle the core takes the held word
  assign in_ready_o = !valid_q || item_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hw/rtl/klo_core.sv
// pulse and lockout state, decision logic and result register
module klo_core import klo_pkg::*; #(
  parameter int unsigned PULSE_BITS    = 16,
  parameter int unsigned INTERVAL_BITS = 20
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  output logic  item_take_o,
  input  item_t item_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  localparam int unsigned CmpW = (INTERVAL_BITS > MinIntW) ? INTERVAL_BITS : MinIntW;
  localparam int unsigned LenW = (PULSE_BITS > DtW) ? PULSE_BITS : DtW;

  logic [PULSE_BITS-1:0]    pulse_left_q, pulse_left_d, pulse_dec;
  logic [INTERVAL_BITS-1:0] since_q, since_d;
  logic                     active_q, active_d;
  logic                     chip_q, chip_d;
  logic                     res_valid_q;
  res_t                     res_q, res_d;
  status_e                  status;

  logic [MaxPulseW-1:0] clamp;
  logic [DtW-1:0]       len_raw;
  logic [LenW-1:0]      len_ext, pulse_max_ext, len_sat;
  logic                 too_soon;

  assign item_take_o = item_valid_i && (!res_valid_q || res_ready_i);

  assign clamp   = (cfg_i.max_pulse_us == '0) ? MaxPulseW'(1) : cfg_i.max_pulse_us;
  assign len_raw = (item_i.discharge_time < clamp) ? item_i.discharge_time : clamp;
  assign len_ext       = LenW'(len_raw);
  assign pulse_max_ext = LenW'({PULSE_BITS{1'b1}});
  // narrow counters saturate the length to what they can hold
  assign len_sat = (len_ext > pulse_max_ext) ? pulse_max_ext : len_ext;

  assign too_soon  = CmpW'(since_q) < CmpW'(cfg_i.min_interval_us);
  assign pulse_dec = (pulse_left_q == '0) ? pulse_left_q : pulse_left_q - 1'b1;

  always_comb begin
    pulse_left_d = pulse_left_q;
    since_d      = since_q;
    active_d     = active_q;
    chip_d       = chip_q;
    status       = ST_TICK;
    if (!item_i.req_type) begin
      status  = ST_TICK;
      since_d = (since_q == '1) ? since_q : since_q + 1'b1;
      if (active_q) begin
        pulse_left_d = pulse_dec;
        if (pulse_dec == '0) begin
          active_d = 1'b0;
        end
      end
    end else if (item_i.discharge_time == '0) begin
      status = ST_ZERO;
    end else if (active_q) begin
      status = ST_BUSY;
    end else if (too_soon) begin
      status = ST_SOON;
    end else begin
      status       = ST_START;
      since_d      = '0;
      pulse_left_d = len_sat[PULSE_BITS-1:0];
      active_d     = 1'b1;
      chip_d       = !item_i.kick_mode_raw;
    end
  end

  always_comb begin
    res_d.chip_line  = active_d && chip_d;
    res_d.shoot_line = active_d && !chip_d;
    res_d.pulse_busy = active_d;
    res_d.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_left_q <= '0;
      since_q      <= '0;
      active_q     <= 1'b0;
      chip_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (item_take_o) begin
        pulse_left_q <= pulse_left_d;
        since_q      <= since_d;
        active_q     <= active_d;
        chip_q       <= chip_d;
      end
      if (item_take_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### tb/sv/klo_checker.sv
// checker for the kick driver: watches all channels, predicts each result word and compares
`timescale 1ns / 100ps

module klo_checker import klo_pkg::*; #(
  parameter int unsigned PULSE_BITS    = 16,
  parameter int unsigned INTERVAL_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // discharge_time, kick_mode_raw
  input  logic                 s_axis_tuser,   // req_type
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,   // chip_line, shoot_line, pulse_busy
  input  logic [StatusW-1:0]   m_axis_tuser,   // status
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   fail_cnt_o,
  output int                   pending_o
);

  localparam logic [PULSE_BITS-1:0] PulseTop = '1;

  logic [MinIntW-1:0]       min_gap_q;
  logic [MaxPulseW-1:0]     clamp_q;
  logic [PULSE_BITS-1:0]    left_q;
  logic [INTERVAL_BITS-1:0] elapsed_q;
  logic                     firing_q;
  logic                     chip_sel_q;
  res_t                     levels_q[$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  // advances the kicker state by one word and returns the levels it leaves behind
  function automatic res_t kick_decision(input logic req, input logic [DtW-1:0] dt,
                                         input logic mode);
    status_e                   st;
    logic [MaxPulseW-1:0]      lim;
    logic [DtW-1:0]            len;
    res_t                      r;
    if (!req) begin
      st = ST_TICK;
      if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
      if (firing_q) begin
        if (left_q != '0) left_q = left_q - 1'b1;
        if (left_q == '0) firing_q = 1'b0;
      end
    end else if (dt == '0) begin
      st = ST_ZERO;
    end else if (firing_q) begin
      st = ST_BUSY;
    end else if (32'(elapsed_q) < 32'(min_gap_q)) begin
      st = ST_SOON;
    end else begin
      st  = ST_START;
      lim = (clamp_q == '0) ? MaxPulseW'(1) : clamp_q;
      len = (dt < lim) ? dt : lim;
      // the pulse counter may be narrower than the requested length
      if (32'(len) > 32'(PulseTop)) len = DtW'(PulseTop);
      elapsed_q  = '0;
      left_q     = PULSE_BITS'(len);
      firing_q   = 1'b1;
      chip_sel_q = !mode;
    end
    r.chip_line  = firing_q && chip_sel_q;
    r.shoot_line = firing_q && !chip_sel_q;
    r.pulse_busy = firing_q;
    r.status     = st;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t got;
    res_t want;
    if (!rst_ni) begin
      min_gap_q  = MinIntervalRst;
      clamp_q    = MaxPulseRst;
      left_q     = '0;
      elapsed_q  = '0;
      firing_q   = 1'b0;
      chip_sel_q = 1'b0;
      levels_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          REG_MIN_INTERVAL: min_gap_q = cfg_data_i[MinIntW-1:0];
          REG_MAX_PULSE:    clamp_q   = cfg_data_i[MaxPulseW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        levels_q.push_back(kick_decision(s_axis_tuser, s_axis_tdata[DtW-1:0],
                                         s_axis_tdata[DtW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.chip_line  = m_axis_tdata[0];
        got.shoot_line = m_axis_tdata[1];
        got.pulse_busy = m_axis_tdata[2];
        got.status     = status_e'(m_axis_tuser);
        if (levels_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: result word with nothing expected: chip %0b shoot %0b busy %0b st %0d",
                     $realtime, got.chip_line, got.shoot_line, got.pulse_busy, got.status);
        end else begin
          want = levels_q.pop_front();
          if (got.chip_line !== want.chip_line || got.shoot_line !== want.shoot_line ||
              got.pulse_busy !== want.pulse_busy || got.status !== want.status) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("%0t: mismatch exp chip %0b shoot %0b busy %0b st %0d, got %0b %0b %0b %0d",
                       $realtime, want.chip_line, want.shoot_line, want.pulse_busy,
                       want.status, got.chip_line, got.shoot_line, got.pulse_busy,
                       got.status);
          end
        end
      end
      pending_o = levels_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// top of the kick driver testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import klo_pkg::*;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;   // discharge_time, kick_mode_raw
  logic                 s_axis_tuser  = 1'b0; // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;         // chip_line, shoot_line, pulse_busy
  logic [StatusW-1:0]   m_axis_tuser;         // status
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 calm          = 1'b0;
  int                   fail_cnt;
  int                   pending;

  always #4 clk_i = ~clk_i;

  kicker_pulse_lockout u_top (.*);

  klo_checker u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i,
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
  end

  task automatic send_word(input logic req, input logic [DtW-1:0] dt, input logic mode);
    int gap;
    gap = 0;
    // each cycle idles with the same odds
    while (!calm && $urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(InTdataW-DtW-1){1'b0}}, mode, dt};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every result word is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int             gap_us;
    int             limit_us;
    int             pick;
    logic           req;
    logic [DtW-1:0] dt;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // reset settings: long lockout, a zero-length kick, then a kick that comes too soon
    send_word(1'b1, 16'h0000, 1'b0);
    send_word(1'b1, 16'hffff, 1'b1);
    send_word(1'b0, 16'hffff, 1'b1);
    settle();
    // no lockout, zero clamp acts as one tick
    cfg_write(REG_MIN_INTERVAL, 20'd0);
    cfg_write(REG_MAX_PULSE, 20'd0);
    send_word(1'b1, 16'hffff, 1'b1);
    send_word(1'b1, 16'h0003, 1'b0);
    send_word(1'b1, 16'h0000, 1'b0);
    send_word(1'b0, 16'h0000, 1'b0);
    send_word(1'b1, 16'h0001, 1'b0);
    send_word(1'b0, 16'h1234, 1'b1);
    settle();
    cfg_write(REG_MIN_INTERVAL, 20'd3);
    cfg_write(REG_MAX_PULSE, 20'd65535);
    send_word(1'b1, 16'h0002, 1'b0);
    send_word(1'b0, 16'h0000, 1'b0);
    send_word(1'b0, 16'h0000, 1'b0);
    send_word(1'b1, 16'h0002, 1'b1);
    send_word(1'b0, 16'h0000, 1'b0);
    send_word(1'b0, 16'h0000, 1'b0);
    send_word(1'b1, 16'h0005, 1'b0);
    settle();
    cfg_write(REG_MIN_INTERVAL, 20'hfffff);
    cfg_write(REG_MAX_PULSE, 20'd1);
    send_word(1'b0, 16'h0000, 1'b0);
    send_word(1'b1, 16'h0001, 1'b1);
    send_word(1'b1, 16'h8000, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin gap_us = 0; limit_us = $urandom_range(1, 30); end
        1: begin gap_us = $urandom_range(1, 40); limit_us = 0; end
        2: begin gap_us = $urandom_range(0, 40); limit_us = 65535; end
        default: begin gap_us = $urandom_range(0, 40); limit_us = $urandom_range(1, 30); end
      endcase
      settle();
      cfg_write(REG_MIN_INTERVAL, CfgDataW'(gap_us));
      cfg_write(REG_MAX_PULSE, CfgDataW'(limit_us));
      for (int n = 0; n < 255; n++) begin
        calm = (ph == 3 && n >= 60 && n < 200);
        if (ph == 4 && n == 128) settle();
        req  = ($urandom_range(0, 99) < 40);
        pick = $urandom_range(0, 9);
        // full-range lengths only where the clamp keeps pulses short
        if (pick == 0) dt = '0;
        else if (pick <= 2 && limit_us <= 64) dt = DtW'($urandom_range(0, 65535));
        else dt = DtW'($urandom_range(1, 24));
        send_word(req, dt, 1'($urandom_range(0, 1)));
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    for (int w = 0; w < 5000 && pending != 0; w++) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
